// File: src/leb_pkg.sv
// shared types and constants for the line edit buffer
// no dependencies; used by every module of the block except leb_ram
`default_nettype none

package leb_pkg;

    localparam int LINE_CAP_DEF = 16;
    localparam int CMD_DEPTH    = 2;

    localparam logic [7:0] KEY_ESC       = 8'd27;
    localparam logic [7:0] KEY_EXT       = 8'd51;
    localparam logic [7:0] KEY_DEL       = 8'd126;
    localparam logic [7:0] KEY_RIGHT     = 8'd67;
    localparam logic [7:0] KEY_LEFT      = 8'd68;
    localparam logic [7:0] KEY_HOME      = 8'd72;
    localparam logic [7:0] KEY_BACKSPACE = 8'd127;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SKIP,
        PH_SELECT,
        PH_DELWAIT
    } phase_t;

    typedef enum logic [2:0] {
        OP_LEFT,
        OP_RIGHT,
        OP_HOME,
        OP_DEL,
        OP_BKSP,
        OP_INS
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] key;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SHIFT_RD,
        B_SHIFT_WR,
        B_INS_PUT,
        B_EMIT_RD,
        B_EMIT_OUT
    } back_state_t;

endpackage

`default_nettype wire

// File: src/leb_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module leb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/leb_front.sv
// keystroke front end: escape sequence tracking and command classification
// depends on leb_pkg
`default_nettype none

module leb_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_key,
    input  wire logic          cmd_full,
    output logic               cmd_push,
    output leb_pkg::cmd_t      cmd_out
);

    import leb_pkg::*;

    phase_t phase_reg, phase_next;
    logic   accept;

    assign s_ready = !cmd_full;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (s_key == KEY_ESC) begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP:   phase_next = PH_SELECT;
                PH_SELECT: begin
                    if (s_key == KEY_EXT) begin
                        phase_next = PH_DELWAIT;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DELWAIT: phase_next = PH_IDLE;
                default:    phase_next = PH_IDLE;
            endcase
        end
    end

    // classification
    always_comb begin
        cmd_push    = 1'b0;
        cmd_out.op  = OP_INS;
        cmd_out.key = s_key;
        if (accept) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (s_key == KEY_BACKSPACE) begin
                        cmd_push   = 1'b1;
                        cmd_out.op = OP_BKSP;
                    end else if (s_key != KEY_ESC) begin
                        cmd_push   = 1'b1;
                        cmd_out.op = OP_INS;
                    end
                end
                PH_SELECT: begin
                    if (s_key == KEY_LEFT) begin
                        cmd_push   = 1'b1;
                        cmd_out.op = OP_LEFT;
                    end else if (s_key == KEY_RIGHT) begin
                        cmd_push   = 1'b1;
                        cmd_out.op = OP_RIGHT;
                    end else if (s_key == KEY_HOME) begin
                        cmd_push   = 1'b1;
                        cmd_out.op = OP_HOME;
                    end
                end
                PH_DELWAIT: begin
                    if (s_key == KEY_DEL) begin
                        cmd_push   = 1'b1;
                        cmd_out.op = OP_DEL;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/leb_cmd_fifo.sv
// short command queue between front end and edit engine
// depends on leb_pkg
`default_nettype none

module leb_cmd_fifo #(
    parameter int DEPTH = leb_pkg::CMD_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire leb_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output leb_pkg::cmd_t      pop_data
);

    import leb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    cmd_t            entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;

    assign full      = (count_reg == NW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: src/leb_back.sv
// edit engine: shifts the line in ram, keeps cursor and length, redraws the line
// depends on leb_pkg and leb_ram
`default_nettype none

module leb_back #(
    parameter int LINE_CAP = leb_pkg::LINE_CAP_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cmd_valid,
    input  wire leb_pkg::cmd_t                   cmd_in,
    output logic                                 cmd_pop,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [7:0]                           m_ch,
    output logic                                 m_char_valid,
    output logic [$clog2(LINE_CAP)-1:0]          m_position,
    output logic [$clog2(LINE_CAP+1)-1:0]        m_cursor_pos,
    output logic [$clog2(LINE_CAP+1)-1:0]        m_line_length,
    output logic                                 m_last
);

    import leb_pkg::*;

    localparam int AW = $clog2(LINE_CAP);
    localparam int CW = $clog2(LINE_CAP + 1);
    localparam int XW = CW + 1;

    back_state_t   state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] length_reg, length_next;
    logic [7:0]    key_reg, key_next;
    logic          up_reg, up_next;

    logic          valid_reg;
    logic [7:0]    ch_reg;
    logic          char_valid_reg;
    logic [AW-1:0] position_reg;
    logic [CW-1:0] cursor_out_reg;
    logic [CW-1:0] length_out_reg;
    logic          last_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          out_free;
    logic          out_load;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] cursor_x;
    logic [XW-1:0] length_x;
    logic          run_end;

    assign idx_x    = XW'(idx_reg);
    assign cursor_x = XW'(cursor_reg);
    assign length_x = XW'(length_reg);
    assign out_free = !valid_reg || m_ready;
    assign run_end  = (length_reg == '0) || (idx_x + XW'(1) == length_x);

    leb_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAP)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state and datapath registers
    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cursor_next = cursor_reg;
        length_next = length_reg;
        key_next    = key_reg;
        up_next     = up_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    key_next = cmd_in.key;
                    unique case (cmd_in.op)
                        OP_LEFT: begin
                            if (cursor_reg != '0) begin
                                cursor_next = cursor_reg - 1'b1;
                            end
                            idx_next   = '0;
                            state_next = B_EMIT_RD;
                        end
                        OP_RIGHT: begin
                            if (cursor_reg < length_reg) begin
                                cursor_next = cursor_reg + 1'b1;
                            end
                            idx_next   = '0;
                            state_next = B_EMIT_RD;
                        end
                        OP_HOME: begin
                            cursor_next = '0;
                            idx_next    = '0;
                            state_next  = B_EMIT_RD;
                        end
                        OP_DEL: begin
                            if (cursor_reg < length_reg) begin
                                up_next = 1'b0;
                                if (cursor_x + XW'(1) < length_x) begin
                                    idx_next   = cursor_reg[AW-1:0];
                                    state_next = B_SHIFT_RD;
                                end else begin
                                    length_next = length_reg - 1'b1;
                                    idx_next    = '0;
                                    state_next  = B_EMIT_RD;
                                end
                            end
                        end
                        OP_BKSP: begin
                            if (cursor_reg != '0) begin
                                up_next     = 1'b0;
                                cursor_next = cursor_reg - 1'b1;
                                if (cursor_reg < length_reg) begin
                                    idx_next   = AW'(cursor_reg - 1'b1);
                                    state_next = B_SHIFT_RD;
                                end else begin
                                    length_next = length_reg - 1'b1;
                                    idx_next    = '0;
                                    state_next  = B_EMIT_RD;
                                end
                            end
                        end
                        OP_INS: begin
                            if (length_reg < CW'(LINE_CAP)) begin
                                up_next = 1'b1;
                                if (length_reg > cursor_reg) begin
                                    idx_next   = length_reg[AW-1:0];
                                    state_next = B_SHIFT_RD;
                                end else begin
                                    state_next = B_INS_PUT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            B_SHIFT_RD: state_next = B_SHIFT_WR;
            B_SHIFT_WR: begin
                if (up_reg) begin
                    idx_next = idx_reg - 1'b1;
                    if (idx_x - XW'(1) > cursor_x) begin
                        state_next = B_SHIFT_RD;
                    end else begin
                        state_next = B_INS_PUT;
                    end
                end else begin
                    if (idx_x + XW'(2) < length_x) begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_SHIFT_RD;
                    end else begin
                        length_next = length_reg - 1'b1;
                        idx_next    = '0;
                        state_next  = B_EMIT_RD;
                    end
                end
            end
            B_INS_PUT: begin
                length_next = length_reg + 1'b1;
                cursor_next = cursor_reg + 1'b1;
                idx_next    = '0;
                state_next  = B_EMIT_RD;
            end
            B_EMIT_RD: state_next = B_EMIT_OUT;
            B_EMIT_OUT: begin
                if (out_free) begin
                    if (run_end) begin
                        state_next = B_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_EMIT_RD;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // ram control, queue pop, output load
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = ram_rdata;
        ram_raddr = idx_reg;
        cmd_pop   = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            B_IDLE:     cmd_pop = cmd_valid;
            B_SHIFT_RD: ram_raddr = up_reg ? idx_reg - 1'b1 : idx_reg + 1'b1;
            B_SHIFT_WR: ram_we = 1'b1;
            B_INS_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = cursor_reg[AW-1:0];
                ram_wdata = key_reg;
            end
            B_EMIT_RD:  ;
            B_EMIT_OUT: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= B_IDLE;
            cursor_reg <= '0;
            length_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            length_reg <= length_next;
            if (out_load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        key_reg <= key_next;
        up_reg  <= up_next;
        if (out_load) begin
            ch_reg         <= (length_reg == '0) ? 8'd0 : ram_rdata;
            char_valid_reg <= (length_reg != '0);
            position_reg   <= (length_reg == '0) ? '0 : idx_reg;
            cursor_out_reg <= cursor_reg;
            length_out_reg <= length_reg;
            last_reg       <= run_end;
        end
    end

    assign m_valid       = valid_reg;
    assign m_ch          = ch_reg;
    assign m_char_valid  = char_valid_reg;
    assign m_position    = position_reg;
    assign m_cursor_pos  = cursor_out_reg;
    assign m_line_length = length_out_reg;
    assign m_last        = last_reg;

endmodule

`default_nettype wire

// File: src/line_edit_buffer_unit.sv
// top level of the line edit buffer: front end, command queue and edit engine
// depends on leb_pkg, leb_front, leb_cmd_fifo, leb_back
//
// One-line text editor driven by keystroke bytes. ESC, a discarded byte and a
// selector byte move the cursor (C right, D left, H home) or, with 3 then ~,
// delete at the cursor; 127 is backspace and every other byte is inserted at
// the cursor. Each move, and each edit that applies, produces one redraw run on the
// m_ channel, one request per character with m_last on the final one, or a
// single request with m_char_valid low for an empty line; ignored edits
// produce nothing. Keystrokes are taken into a two-entry command queue, so
// escape bytes, and up to two typed-ahead commands, flow in at one per cycle
// while a redraw runs, as long as the queue is not full.
// The edit engine works through the line RAM's single read port with
// registered read: each character moved in the line takes a read state and a
// write state, an insert adds one write, and each redraw result takes a read
// state and an output state that waits for m_ready.
// The line store has no reset; only data from written entries is ever used.
`default_nettype none

module line_edit_buffer_unit #(
    parameter int LINE_CAP = leb_pkg::LINE_CAP_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_key,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_ch,
    output logic                                m_char_valid,
    output logic [$clog2(LINE_CAP)-1:0]         m_position,
    output logic [$clog2(LINE_CAP+1)-1:0]       m_cursor_pos,
    output logic [$clog2(LINE_CAP+1)-1:0]       m_line_length,
    output logic                                m_last
);

    import leb_pkg::*;

    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic push;
    logic full;
    logic pop;
    logic not_empty;

    leb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_key    (s_key),
        .cmd_full (full),
        .cmd_push (push),
        .cmd_out  (push_cmd)
    );

    leb_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_cmd)
    );

    leb_back #(
        .LINE_CAP (LINE_CAP)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (not_empty),
        .cmd_in        (pop_cmd),
        .cmd_pop       (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ch          (m_ch),
        .m_char_valid  (m_char_valid),
        .m_position    (m_position),
        .m_cursor_pos  (m_cursor_pos),
        .m_line_length (m_line_length),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

// File: src/leb_checker.sv
// port-level checks on the redraw channel of the line edit buffer
// depends on line_edit_buffer_unit, attached by the bind at the end
`default_nettype none

module leb_checker #(
    parameter int LINE_CAP = leb_pkg::LINE_CAP_DEF
) (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [7:0]                     m_ch,
    input wire logic                           m_char_valid,
    input wire logic [$clog2(LINE_CAP)-1:0]    m_position,
    input wire logic [$clog2(LINE_CAP+1)-1:0]  m_cursor_pos,
    input wire logic [$clog2(LINE_CAP+1)-1:0]  m_line_length,
    input wire logic                           m_last
);

    localparam int CW = $clog2(LINE_CAP + 1);

    // stalled request holds its valid, character, position and last flag
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ch) && $stable(m_position)
            && $stable(m_last))
        else $error("stalled redraw request changed");

    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_line_length <= CW'(LINE_CAP) && m_cursor_pos <= m_line_length)
        else $error("cursor or length out of range");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_char_valid |-> m_last && m_position == '0
            && m_line_length == '0 && m_ch == 8'd0)
        else $error("bad empty line request");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_valid |-> CW'(m_position) < m_line_length
            && (m_last == (CW'(m_position) + CW'(1) == m_line_length)))
        else $error("position or last flag inconsistent");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("redraw request after reset");

endmodule

bind line_edit_buffer_unit leb_checker #(
    .LINE_CAP (LINE_CAP)
) u_leb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_ch          (m_ch),
    .m_char_valid  (m_char_valid),
    .m_position    (m_position),
    .m_cursor_pos  (m_cursor_pos),
    .m_line_length (m_line_length),
    .m_last        (m_last)
);

`default_nettype wire
